### hdl/gcm_pkg.sv
// gcm_pkg: shared types and constants of the greedy change maker.
// Field widths, command and register codes, state encoding, RAM slot layout.
// No dependencies.
`default_nettype none

package gcm_pkg;

  // Field widths
  localparam int CMD_W        = 1;
  localparam int IDX_W        = 2;
  localparam int CNT_W        = 8;
  localparam int AMT_W        = 16;
  localparam int VAL_W        = 16;
  localparam int DNU_W        = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int PROD_W       = VAL_W + CNT_W;
  localparam int NUM_VAL_REGS = 4;

  // Request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 1'b0,
    CMD_CHANGE = 1'b1
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DENOM_VALUE_0 = 3'd0,
    REG_DENOM_VALUE_1 = 3'd1,
    REG_DENOM_VALUE_2 = 3'd2,
    REG_DENOM_VALUE_3 = 3'd3,
    REG_DENOMS_IN_USE = 3'd4
  } cfg_reg_t;

  // Reset values of the configuration registers
  localparam logic [VAL_W-1:0] DENOM_RESET [NUM_VAL_REGS] = '{16'd1, 16'd2, 16'd5, 16'd10};
  localparam logic [DNU_W-1:0] DNU_RESET = 3'd4;

  // One RAM entry per denomination: coins handed out by the last request and stock
  typedef struct packed {
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] stock;
  } slot_t;

  localparam int SLOT_W = 2 * CNT_W;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [AMT_W-1:0] dividend;
    logic [VAL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [AMT_W-1:0] quotient;
  } div_rsp_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM_RD,
    ST_SUM_MUL,
    ST_SUM_ACC,
    ST_GRD_RD,
    ST_GRD_DIV,
    ST_GRD_WAIT,
    ST_GRD_MUL,
    ST_GRD_UPD,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } gcm_state_t;

endpackage

`default_nettype wire

### hdl/gcm_in_if.sv
// gcm_in_if: request channel of the change maker (load or change request).
// Depends on gcm_pkg for field widths.
`default_nettype none

interface gcm_in_if;
  import gcm_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] denom_index;
  logic [CNT_W-1:0] stock_count;
  logic [AMT_W-1:0] amount;

  modport source (output valid, output cmd, output denom_index, output stock_count,
                  output amount, input ready);
  modport sink   (input valid, input cmd, input denom_index, input stock_count,
                  input amount, output ready);
endinterface

`default_nettype wire

### hdl/gcm_out_if.sv
// gcm_out_if: result channel of the change maker, one result per denomination.
// Depends on gcm_pkg for field widths.
`default_nettype none

interface gcm_out_if;
  import gcm_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] result_index;
  logic [CNT_W-1:0] coins_used;
  logic             success;
  logic             last;

  modport source (output valid, output result_index, output coins_used, output success,
                  output last, input ready);
  modport sink   (input valid, input result_index, input coins_used, input success,
                  input last, output ready);
endinterface

`default_nettype wire

### hdl/gcm_cfg_if.sv
// gcm_cfg_if: configuration write channel (register index and write data).
// Depends on gcm_pkg for field widths.
`default_nettype none

interface gcm_cfg_if;
  import gcm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/gcm_ram.sv
// gcm_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none

module gcm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port; read data holds when not reading
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hdl/gcm_div.sv
// gcm_div: restoring divider, one quotient bit per cycle.
// Depends on gcm_pkg for widths and the request/response structs.
`default_nettype none

module gcm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  gcm_pkg::div_req_t  req,
  output gcm_pkg::div_rsp_t  rsp
);
  import gcm_pkg::*;

  localparam int STEP_W = $clog2(AMT_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [VAL_W-1:0]  rem_r;
  logic [VAL_W-1:0]  dvs_r;
  logic [AMT_W-1:0]  quo_r;

  logic [VAL_W:0]    shifted;
  logic [VAL_W+1:0]  diff;
  logic              neg;

  // Trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    shifted = {rem_r, quo_r[AMT_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_r};
    neg     = diff[VAL_W+1];
  end

  // Control: count down the quotient bits, pulse done on the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(AMT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      if (!neg) begin
        rem_r <= diff[VAL_W-1:0];
        quo_r <= {quo_r[AMT_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[VAL_W-1:0];
        quo_r <= {quo_r[AMT_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

### hdl/greedy_change_maker.sv
// greedy_change_maker: greedy change making from limited coin stock.
// Load request: stock written from the idle state, no result. Change request, per active
// denomination: stock summing (read, multiply, accumulate); if the stock covers the amount,
// greedy walk (read, divider start and wait, multiply, write-back); then results handed out
// (read, output). One request at a time; the next is taken while the last result waits.
// Synchronous active-low reset: stock reads as zero, registers take reset values.
`default_nettype none

module greedy_change_maker #(
  parameter int MAX_DENOMS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  gcm_in_if.sink    in_ch,
  gcm_out_if.source out_ch,
  gcm_cfg_if.sink   cfg_ch
);
  import gcm_pkg::*;

  localparam int KW    = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
  localparam int CW    = $clog2(MAX_DENOMS + 1);
  localparam int TOT_W = PROD_W + CW;

  // Configuration registers
  logic [VAL_W-1:0] val_r [NUM_VAL_REGS];
  logic [DNU_W-1:0] dnu_r;

  // Sequencer and datapath registers
  gcm_state_t       state_r, state_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [AMT_W-1:0] rem_r, rem_nxt;
  logic [AMT_W-1:0] amount_r, amount_nxt;
  logic [CNT_W-1:0] stock_r, stock_nxt;
  logic [CNT_W-1:0] take_r, take_nxt;
  logic             ok_r, ok_nxt;

  // Output register
  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [CNT_W-1:0] out_used_r;
  logic             out_succ_r;
  logic             out_last_r;
  logic             out_load;

  // Stock RAM and its valid bits
  logic              ram_wr_en;
  logic [KW-1:0]     ram_wr_addr;
  slot_t             ram_wr_data;
  logic              ram_rd_en;
  logic [KW-1:0]     ram_rd_addr;
  logic [SLOT_W-1:0] ram_rd_data;
  logic [MAX_DENOMS-1:0] vld_r;
  logic              rd_vld_r;
  slot_t             rd_slot;

  // Divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Derived values
  logic [CW-1:0]     n_act;
  logic [KW-1:0]     last_k;
  logic [3:0]        kx;
  logic [3:0]        ld_idx;
  logic              ld_ok;
  logic [VAL_W-1:0]  cur_val;
  logic [TOT_W-1:0]  sum_acc;
  logic [AMT_W-1:0]  rem_after;
  logic              in_acc;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;

  // Write configuration registers; drop writes to absent denominations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_VAL_REGS; i++) begin
        val_r[i] <= DENOM_RESET[i];
      end
      dnu_r <= DNU_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_DENOM_VALUE_0, REG_DENOM_VALUE_1, REG_DENOM_VALUE_2, REG_DENOM_VALUE_3: begin
          if (32'(cfg_ch.index) < MAX_DENOMS) begin
            val_r[cfg_ch.index[1:0]] <= cfg_ch.data;
          end
        end
        REG_DENOMS_IN_USE: begin
          dnu_r <= cfg_ch.data[DNU_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Clamp the active count to 1..MAX_DENOMS
  always_comb begin
    if (dnu_r == '0) begin
      n_act = CW'(1);
    end else if (32'(dnu_r) > MAX_DENOMS) begin
      n_act = CW'(MAX_DENOMS);
    end else begin
      n_act = CW'(dnu_r);
    end
    last_k = KW'(n_act - CW'(1));
  end

  // Value of the current denomination; those without a register are zero
  always_comb begin
    kx      = 4'(k_r);
    cur_val = (kx < 4'(NUM_VAL_REGS)) ? val_r[kx[1:0]] : '0;
    ld_idx  = 4'(in_ch.denom_index);
    ld_ok   = (32'(in_ch.denom_index) < MAX_DENOMS);
  end

  // Entries never written read as zero stock
  assign rd_slot   = rd_vld_r ? slot_t'(ram_rd_data) : '0;
  assign sum_acc   = total_r + TOT_W'(prod_r);
  assign rem_after = rem_r - prod_r[AMT_W-1:0];

  // Sequencer: next state, RAM and divider control
  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    total_nxt    = total_r;
    prod_nxt     = prod_r;
    rem_nxt      = rem_r;
    amount_nxt   = amount_r;
    stock_nxt    = stock_r;
    take_nxt     = take_r;
    ok_nxt       = ok_r;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = k_r;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = k_r;
    ram_wr_data  = '0;
    div_req.start    = 1'b0;
    div_req.dividend = rem_r;
    div_req.divisor  = cur_val;
    out_load     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.cmd == CMD_LOAD) begin
            ram_wr_en         = ld_ok;
            ram_wr_addr       = ld_idx[KW-1:0];
            ram_wr_data.used  = '0;
            ram_wr_data.stock = in_ch.stock_count;
          end else begin
            amount_nxt = in_ch.amount;
            k_nxt      = '0;
            total_nxt  = '0;
            state_nxt  = ST_SUM_RD;
          end
        end
      end

      // Sum the stock value, clearing the used counts on the way
      ST_SUM_RD: begin
        ram_rd_en = 1'b1;
        state_nxt = ST_SUM_MUL;
      end

      ST_SUM_MUL: begin
        prod_nxt          = {8'b0, cur_val} * {16'b0, rd_slot.stock};
        ram_wr_en         = 1'b1;
        ram_wr_data.used  = '0;
        ram_wr_data.stock = rd_slot.stock;
        state_nxt         = ST_SUM_ACC;
      end

      ST_SUM_ACC: begin
        total_nxt = sum_acc;
        if (k_r == last_k) begin
          if (sum_acc < TOT_W'(amount_r)) begin
            ok_nxt    = 1'b0;
            k_nxt     = '0;
            state_nxt = ST_EMIT_RD;
          end else begin
            rem_nxt   = amount_r;
            k_nxt     = last_k;
            state_nxt = ST_GRD_RD;
          end
        end else begin
          k_nxt     = k_r + KW'(1);
          state_nxt = ST_SUM_RD;
        end
      end

      // Greedy walk from the highest active denomination index down
      ST_GRD_RD: begin
        ram_rd_en = 1'b1;
        state_nxt = ST_GRD_DIV;
      end

      ST_GRD_DIV: begin
        stock_nxt = rd_slot.stock;
        if (cur_val == '0) begin
          take_nxt  = '0;
          prod_nxt  = '0;
          state_nxt = ST_GRD_UPD;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_GRD_WAIT;
        end
      end

      ST_GRD_WAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient > AMT_W'(stock_r)) begin
            take_nxt = stock_r;
          end else begin
            take_nxt = div_rsp.quotient[CNT_W-1:0];
          end
          state_nxt = ST_GRD_MUL;
        end
      end

      ST_GRD_MUL: begin
        prod_nxt  = {16'b0, take_r} * {8'b0, cur_val};
        state_nxt = ST_GRD_UPD;
      end

      ST_GRD_UPD: begin
        rem_nxt           = rem_after;
        ram_wr_en         = 1'b1;
        ram_wr_data.used  = take_r;
        ram_wr_data.stock = stock_r - take_r;
        if (k_r == '0) begin
          ok_nxt    = (rem_after == '0);
          state_nxt = ST_EMIT_RD;
        end else begin
          k_nxt     = k_r - KW'(1);
          state_nxt = ST_GRD_RD;
        end
      end

      // Hand out one result per active denomination, index 0 upward
      ST_EMIT_RD: begin
        ram_rd_en = 1'b1;
        state_nxt = ST_EMIT_OUT;
      end

      ST_EMIT_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load = 1'b1;
          if (k_r == last_k) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + KW'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (ram_wr_en) begin
        vld_r[ram_wr_addr] <= 1'b1;
      end
      if (ram_rd_en) begin
        rd_vld_r <= vld_r[ram_rd_addr];
      end
    end
  end

  // Datapath and output payload registers
  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    total_r  <= total_nxt;
    prod_r   <= prod_nxt;
    rem_r    <= rem_nxt;
    amount_r <= amount_nxt;
    stock_r  <= stock_nxt;
    take_r   <= take_nxt;
    ok_r     <= ok_nxt;
    if (out_load) begin
      out_idx_r  <= kx[IDX_W-1:0];
      out_used_r <= rd_slot.used;
      out_succ_r <= ok_r;
      out_last_r <= (k_r == last_k);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_index = out_idx_r;
  assign out_ch.coins_used   = out_used_r;
  assign out_ch.success      = out_succ_r;
  assign out_ch.last         = out_last_r;

  // Stock and used counts, one entry per denomination
  gcm_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_DENOMS)
  ) u_stock_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Coins per denomination: remaining amount over coin value
  gcm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

`default_nettype wire

### hdl/gcm_checker.sv
// gcm_checker: port-level assertions for greedy_change_maker, with its bind.
// Depends on gcm_pkg for field widths and command codes.
`default_nettype none

module gcm_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [gcm_pkg::CMD_W-1:0] in_cmd,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [gcm_pkg::IDX_W-1:0] out_result_index,
  input logic [gcm_pkg::CNT_W-1:0] out_coins_used,
  input logic                      out_success,
  input logic                      out_last
);
  import gcm_pkg::*;

  logic             out_acc;
  logic [IDX_W-1:0] exp_idx_r;
  logic             first_r;
  logic             succ_r;

  assign out_acc = out_valid && out_ready;

  // Track position within the results of one request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
      first_r   <= 1'b1;
      succ_r    <= 1'b0;
    end else if (out_acc) begin
      exp_idx_r <= out_last ? '0 : exp_idx_r + IDX_W'(1);
      first_r   <= out_last;
      succ_r    <= out_success;
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable({out_result_index, out_coins_used, out_success, out_last}))
    else $error("stalled result changed");

  // Results of a request count up from denomination zero
  a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> out_result_index == exp_idx_r)
    else $error("result index out of order");

  // Success flag is the same across one request
  a_success_const: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !first_r |-> out_success == succ_r)
    else $error("success flag changed within a request");

  // A change request blocks the next request while it is worked on
  a_busy_after_change: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_CHANGE |=> !in_ready)
    else $error("request taken while change request in progress");

endmodule

bind greedy_change_maker gcm_checker u_gcm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_cmd           (in_ch.cmd),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result_index (out_ch.result_index),
  .out_coins_used   (out_ch.coins_used),
  .out_success      (out_ch.success),
  .out_last         (out_ch.last)
);

`default_nettype wire
